[rtl/core/bmpx_pkg.sv]
package bmpx_pkg;

    // Fixed field widths of the stream.
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned INDEX_W     = 8;
    localparam int unsigned MSG_BIT_W   = 3;
    localparam int unsigned POS_W       = 32;

    // BMP header layout: the pixel-data offset sits in bytes 10 to 13.
    localparam int unsigned HEADER_BYTES = 54;
    localparam int unsigned OFFSET_FIRST = 10;
    localparam int unsigned OFFSET_LAST  = 13;

    localparam int unsigned LENGTH_BITS_DEFAULT = 8;

    localparam int unsigned QUEUE_DEPTH = 2;

    // One decoded pixel-data byte handed from the front to the back.
    typedef struct packed {
        logic lsb;
        logic first;
    } op_t;

    typedef struct packed {
        logic [INDEX_W-1:0] message_index;
        logic [BYTE_W-1:0]  message_byte;
        logic               message_last;
    } result_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_LENGTH  = 3'b010,
        PH_MESSAGE = 3'b100
    } phase_t;

endpackage

[rtl/core/bmpx_front.sv]
module bmpx_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bmpx_pkg::BYTE_W-1:0] s_tdata,   // [7:0] file_byte
    input  logic                        s_tuser,   // [0] file_start
    input  logic                        q_ready,
    output logic                        q_push,
    output bmpx_pkg::op_t               q_op
);
    import bmpx_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] offset_reg, offset_next;
    logic             header_reg, header_next;

    logic [POS_W-1:0] eff_pos;
    logic [POS_W-1:0] eff_offset;
    logic             eff_header;
    logic             in_data;
    logic             accept;
    logic [1:0]       lane;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        // A file start restarts the parser before this item is handled.
        eff_pos     = s_tuser ? '0 : pos_reg;
        eff_offset  = s_tuser ? '0 : offset_reg;
        eff_header  = s_tuser ? 1'b1 : header_reg;
        lane        = eff_pos[1:0] + 2'd2;
        offset_next = eff_offset;
        if (eff_header && eff_pos >= POS_W'(OFFSET_FIRST) && eff_pos <= POS_W'(OFFSET_LAST))
        begin
            offset_next[lane*BYTE_W +: BYTE_W] = s_tdata;
        end
        in_data     = !eff_header ||
                      (eff_pos >= POS_W'(HEADER_BYTES) && eff_pos >= offset_next);
        pos_next    = (eff_pos == '1) ? eff_pos : eff_pos + POS_W'(1);
        header_next = eff_header && !in_data;
        q_push      = accept && in_data;
        q_op.lsb    = s_tdata[0];
        q_op.first  = eff_header;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            offset_reg <= '0;
            header_reg <= 1'b1;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            header_reg <= header_next;
        end
    end

    a_start_stays_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser) |=> header_reg)
        else $error("file start left the header phase");

endmodule

[rtl/core/bmpx_queue.sv]
module bmpx_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bmpx_pkg::op_t push_op,
    output logic          ready,
    output logic          valid,
    output bmpx_pkg::op_t head_op,
    input  logic          pop
);
    import bmpx_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign ready   = count_reg != CNT_W'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign head_op = mem_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ready)
        else $error("push into a full queue");

endmodule

[rtl/core/bmpx_back.sv]
module bmpx_back #(
    parameter int unsigned LENGTH_BITS = bmpx_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  bmpx_pkg::op_t      q_op,
    output logic               q_pop,
    output logic               out_valid,
    output bmpx_pkg::result_t  out_result,
    input  logic               out_ready
);
    import bmpx_pkg::*;

    localparam int unsigned BIT_W = $clog2(LENGTH_BITS);

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] hidden_reg, hidden_next;
    logic [LENGTH_BITS-1:0] emitted_reg, emitted_next;
    logic [BIT_W-1:0]       idx_reg, idx_next;
    logic [BYTE_W-1:0]      asm_reg, asm_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    phase_t                 op_phase;
    logic [LENGTH_BITS-1:0] hidden_cur;
    logic [LENGTH_BITS-1:0] emitted_inc;
    logic [BIT_W-1:0]       idx_cur;
    logic [BYTE_W-1:0]      asm_new;
    logic                   emit;
    logic                   last;

    assign q_pop      = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        hidden_next  = hidden_reg;
        emitted_next = emitted_reg;
        idx_next     = idx_reg;
        asm_next     = asm_reg;
        out_next     = out_reg;
        emit         = 1'b0;
        // The first pixel-data byte of a file starts a fresh length field.
        op_phase     = q_op.first ? PH_LENGTH : phase_reg;
        hidden_cur   = q_op.first ? '0 : hidden_reg;
        idx_cur      = q_op.first ? '0 : idx_reg;
        emitted_inc  = emitted_reg + LENGTH_BITS'(1);
        last         = emitted_inc == hidden_reg;
        asm_new      = asm_reg | (BYTE_W'(q_op.lsb) << idx_cur[MSG_BIT_W-1:0]);
        if (q_pop)
        begin
            unique case (op_phase)
                PH_IDLE:
                begin
                end
                PH_LENGTH:
                begin
                    hidden_next = hidden_cur | (LENGTH_BITS'(q_op.lsb) << idx_cur);
                    if (idx_cur == BIT_W'(LENGTH_BITS - 1))
                    begin
                        idx_next     = '0;
                        asm_next     = '0;
                        emitted_next = '0;
                        phase_next   = (hidden_next == '0) ? PH_IDLE : PH_MESSAGE;
                    end
                    else
                    begin
                        idx_next   = idx_cur + BIT_W'(1);
                        phase_next = PH_LENGTH;
                    end
                end
                PH_MESSAGE:
                begin
                    if (idx_cur[MSG_BIT_W-1:0] == '1)
                    begin
                        emit                  = 1'b1;
                        out_next.message_byte  = asm_new;
                        out_next.message_index = emitted_reg[INDEX_W-1:0];
                        out_next.message_last  = last;
                        emitted_next          = emitted_inc;
                        idx_next              = '0;
                        asm_next              = '0;
                        if (last)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        asm_next = asm_new;
                        idx_next = idx_cur + BIT_W'(1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hidden_reg    <= '0;
            emitted_reg   <= '0;
            idx_reg       <= '0;
            asm_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hidden_reg    <= hidden_next;
            emitted_reg   <= emitted_next;
            idx_reg       <= idx_next;
            asm_reg       <= asm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_first_starts_length: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_op.first) |=> (phase_reg == PH_LENGTH))
        else $error("first pixel byte did not start the length field");

    a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> (phase_reg == PH_IDLE && out_valid_reg))
        else $error("last message item did not end the message");

    a_emit_only_in_message: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (phase_reg == PH_MESSAGE && !q_op.first))
        else $error("item emitted outside the message phase");

endmodule

[rtl/core/bmp_lsb_message_extractor_core.sv]
// Extracts a message hidden in the least significant bits of a BMP file's
// pixel bytes. The file streams in one byte per item on the s_ side, with
// tuser set on the first byte of each file. The header is parsed for the
// pixel-data offset (an offset below 54 counts as 54), the first LENGTH_BITS
// pixel bytes give the message length, and each following group of 8 pixel
// bytes yields one message item on the m_ side, tlast set on the final byte.
// The s_ side takes one byte per clock while the queue has room. The front
// parses the header and passes pixel bytes through a two-entry queue to the
// back, which assembles bytes into a registered output; a message byte passes
// the queue and then the output register. The rate is set by the back, which
// takes one queued byte per cycle whenever its output register is free.
module bmp_lsb_message_extractor_core #(
    parameter int unsigned LENGTH_BITS = bmpx_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    input  logic [bmpx_pkg::BYTE_W-1:0]                     s_tdata,  // [7:0] file_byte
    input  logic                                            s_tuser,  // [0] file_start
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    // [7:0] message_byte, [15:8] message_index
    output logic [bmpx_pkg::BYTE_W+bmpx_pkg::INDEX_W-1:0]   m_tdata,
    output logic                                            m_tlast
);
    import bmpx_pkg::*;

    logic    q_push, q_ready, q_valid, q_pop;
    op_t     push_op, head_op;
    result_t result;

    bmpx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    bmpx_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .ready   (q_ready),
        .valid   (q_valid),
        .head_op (head_op),
        .pop     (q_pop)
    );

    bmpx_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_op       (head_op),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_result (result),
        .out_ready  (m_tready)
    );

    assign m_tdata = {result.message_index, result.message_byte};
    assign m_tlast = result.message_last;

endmodule
